[sv/lct_pkg.sv]
// Shared types and codes for the client table with timeout.
`timescale 1ns / 1ps

package lct_pkg;

	// request codes
	localparam logic [1:0] OP_CONNECT  = 2'd0;
	localparam logic [1:0] OP_ACTIVITY = 2'd1;
	localparam logic [1:0] OP_CLOSE    = 2'd2;
	localparam logic [1:0] OP_TICK     = 2'd3;

	// register indexes on the configuration port
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SWEEP   = 1'b1;

	localparam logic [31:0] TIMEOUT_RST  = 32'd30000;
	localparam logic [31:0] INTERVAL_RST = 32'd5000;

	// slot index width, wide enough for the largest table plus one
	localparam int IDX_W = 7;

	// word that travels down the cell row
	typedef struct packed {
		logic             valid;
		logic [1:0]       op;
		logic [15:0]      id;
		logic [31:0]      now;
		logic             sweep;
		logic [IDX_W-1:0] start;
		logic             emit;
		logic [IDX_W-1:0] emit_idx;
		logic [15:0]      emit_sock;
		logic             match;
		logic [IDX_W-1:0] match_idx;
		logic             match_en;
		logic             empty;
		logic [IDX_W-1:0] empty_idx;
		logic [31:0]      best_age;
		logic [IDX_W-1:0] best_idx;
		logic [15:0]      best_sock;
	} lct_word_t;

	// slot update broadcast from the controller
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic             wr_sock;
		logic [15:0]      sock;
		logic             wr_time;
		logic [31:0]      now;
		logic             wr_en;
		logic             en;
	} lct_upd_t;

endpackage

[sv/lct_cell.sv]
// One table slot: holds its client and updates the passing word.
`timescale 1ns / 1ps

module lct_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lct_pkg::lct_word_t word_in,
	output lct_pkg::lct_word_t word_out,
	input  lct_pkg::lct_upd_t  upd,
	input  logic [31:0]        timeout
);

	localparam logic [lct_pkg::IDX_W-1:0] IDX_V  = lct_pkg::IDX_W'(IDX);
	localparam logic [lct_pkg::IDX_W-1:0] NEXT_V = lct_pkg::IDX_W'(IDX + 1);

	logic [15:0]        sock_q;
	logic [31:0]        time_q;
	logic               en_q;
	lct_pkg::lct_word_t word_q;
	lct_pkg::lct_word_t w;
	logic [31:0]        age;
	logic               occupied;
	logic               act;
	logic               expire;
	logic               hit_upd;

	assign age      = word_in.now - time_q;
	assign occupied = (sock_q != 16'd0);
	assign act      = word_in.valid && !word_in.emit && (IDX_V >= word_in.start);
	assign hit_upd  = upd.we && (upd.idx == IDX_V);

	always_comb begin
		w      = word_in;
		expire = 1'b0;
		if (act) begin
			if (word_in.op == lct_pkg::OP_TICK) begin
				// free an expired client and carry it to the end of the row
				if (word_in.sweep && occupied && (age > timeout)) begin
					expire      = 1'b1;
					w.emit      = 1'b1;
					w.emit_idx  = IDX_V;
					w.emit_sock = sock_q;
					w.start     = NEXT_V;
				end
			end else begin
				if (!word_in.match && (sock_q == word_in.id)) begin
					w.match     = 1'b1;
					w.match_idx = IDX_V;
					w.match_en  = en_q;
				end
				if (!word_in.empty && !occupied) begin
					w.empty     = 1'b1;
					w.empty_idx = IDX_V;
				end
				if ((IDX == 0) || (age > word_in.best_age)) begin
					w.best_age  = age;
					w.best_idx  = IDX_V;
					w.best_sock = sock_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sock_q <= 16'd0;
			en_q   <= 1'b0;
			word_q <= '0;
		end else begin
			word_q <= w;
			if (expire) begin
				sock_q <= 16'd0;
				en_q   <= 1'b0;
			end else if (hit_upd) begin
				if (upd.wr_sock) begin
					sock_q <= upd.sock;
				end
				if (upd.wr_en) begin
					en_q <= upd.en;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!expire && hit_upd && upd.wr_time) begin
			time_q <= upd.now;
		end
	end

	assign word_out = word_q;

endmodule

[sv/lct_chain.sv]
// Row of slot cells; the word moves one cell per cycle.
`timescale 1ns / 1ps

module lct_chain #(
	parameter int N_CELLS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lct_pkg::lct_word_t word_in,
	output lct_pkg::lct_word_t word_out,
	input  lct_pkg::lct_upd_t  upd,
	input  logic [31:0]        timeout
);

	lct_pkg::lct_word_t link [N_CELLS+1];

	assign link[0] = word_in;

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		lct_cell #(
			.IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.word_in (link[g]),
			.word_out(link[g+1]),
			.upd     (upd),
			.timeout (timeout)
		);
	end

	assign word_out = link[N_CELLS];

endmodule

[sv/lru_client_table_with_timeout_top.sv]
// Top level: request intake, result decision and output register of the client table.
`timescale 1ns / 1ps

// Client table with least-recently-used eviction and inactivity timeout.
// Requests enter on the s_ group: s_tuser carries the request code (connect,
// activity, close, tick), s_tdata the socket id and the current time. Each
// request gives one result on the m_ group, except a tick, which gives one
// word per timed-out client and then a closing word; m_tlast marks the final
// word of every request.
// A request is taken only while no other one is in work. Its word walks the
// row of MAX_CLIENTS cells, one cell per cycle, then the controller writes the
// chosen slot and loads the result, and only then is the next request taken.
// For a tick, the walk starts again at cell 0 after each freed client and
// resumes behind the freed slot. The result sits in an output register, so the
// next request is taken while a result waits; if the receiver stalls, the
// controller holds at its decision step until the output register frees up.
// Reset empties every slot, clears the last sweep time and loads a timeout of
// 30000 and a sweep interval of 5000. Configuration is written through
// cfg_we / cfg_addr / cfg_wdata while the block is idle; the user must keep to
// this, as the block itself does not enforce it.
module lru_client_table_with_timeout_top #(
	parameter int MAX_CLIENTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,   // socket_id[15:0], now_ms[47:16]
	input  logic [1:0]                     s_tuser,   // op[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// slot[2:0], found[3], client_enabled[4], closed_socket[20:5], close_now[21], zero[23:22]
	output logic [23:0]                    m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [lct_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]                    cfg_wdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;

	logic [1:0]         state_q;
	logic [31:0]        timeout_q;
	logic [31:0]        interval_q;
	logic [31:0]        last_sweep_q;
	lct_pkg::lct_word_t inj_s0;
	lct_pkg::lct_word_t fin_q;
	lct_pkg::lct_word_t chain_out;
	lct_pkg::lct_word_t new_word;
	lct_pkg::lct_word_t resume_word;
	lct_pkg::lct_upd_t  upd;

	logic        m_valid_q;
	logic [2:0]  out_slot_q;
	logic        out_found_q;
	logic        out_en_q;
	logic [15:0] out_closed_q;
	logic        out_cnow_q;
	logic        out_last_q;

	logic        accept;
	logic        out_free;
	logic        push;
	logic        reinject;
	logic        sweep_done;
	logic [2:0]  r_slot;
	logic        r_found;
	logic        r_en;
	logic [15:0] r_closed;
	logic        r_cnow;
	logic        r_last;
	logic [lct_pkg::IDX_W-1:0] new_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign push     = (state_q == ST_END) && out_free;

	always_comb begin
		new_word       = '0;
		new_word.valid = 1'b1;
		new_word.op    = s_tuser;
		new_word.id    = s_tdata[15:0];
		new_word.now   = s_tdata[47:16];
		new_word.sweep = (s_tuser == lct_pkg::OP_TICK) &&
		                 ((s_tdata[47:16] - last_sweep_q) > interval_q);
	end

	always_comb begin
		resume_word      = fin_q;
		resume_word.emit = 1'b0;
	end

	assign new_idx = fin_q.empty ? fin_q.empty_idx : fin_q.best_idx;

	// decide the result word and slot update from the word that left the row
	always_comb begin
		r_slot     = 3'd0;
		r_found    = 1'b0;
		r_en       = 1'b0;
		r_closed   = 16'd0;
		r_cnow     = 1'b0;
		r_last     = 1'b1;
		reinject   = 1'b0;
		sweep_done = 1'b0;
		upd        = '0;
		upd.now    = fin_q.now;
		if (fin_q.op == lct_pkg::OP_TICK) begin
			if (fin_q.emit) begin
				r_slot   = fin_q.emit_idx[2:0];
				r_found  = 1'b1;
				r_closed = fin_q.emit_sock;
				r_cnow   = 1'b1;
				r_last   = 1'b0;
				reinject = 1'b1;
			end else begin
				sweep_done = fin_q.sweep;
			end
		end else if (fin_q.id != 16'd0) begin
			case (fin_q.op)
				lct_pkg::OP_CONNECT: begin
					if (fin_q.match) begin
						r_slot      = fin_q.match_idx[2:0];
						r_found     = 1'b1;
						r_en        = fin_q.match_en;
						upd.we      = 1'b1;
						upd.idx     = fin_q.match_idx;
						upd.wr_time = 1'b1;
					end else begin
						r_slot      = new_idx[2:0];
						r_closed    = fin_q.empty ? 16'd0 : fin_q.best_sock;
						r_cnow      = !fin_q.empty && (fin_q.best_sock != 16'd0);
						upd.we      = 1'b1;
						upd.idx     = new_idx;
						upd.wr_sock = 1'b1;
						upd.sock    = fin_q.id;
						upd.wr_time = 1'b1;
						upd.wr_en   = 1'b1;
						upd.en      = 1'b0;
					end
				end
				lct_pkg::OP_ACTIVITY: begin
					if (fin_q.match) begin
						r_slot    = fin_q.match_idx[2:0];
						r_found   = 1'b1;
						r_en      = 1'b1;
						upd.we    = 1'b1;
						upd.idx   = fin_q.match_idx;
						upd.wr_en = 1'b1;
						upd.en    = 1'b1;
					end
				end
				lct_pkg::OP_CLOSE: begin
					if (fin_q.match) begin
						r_slot      = fin_q.match_idx[2:0];
						r_found     = 1'b1;
						upd.we      = 1'b1;
						upd.idx     = fin_q.match_idx;
						upd.wr_sock = 1'b1;
						upd.sock    = 16'd0;
						upd.wr_en   = 1'b1;
						upd.en      = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		// write the slot only in the cycle the result goes out
		upd.we = upd.we && push;
	end

	lct_chain #(
		.N_CELLS(MAX_CLIENTS)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_in (inj_s0),
		.word_out(chain_out),
		.upd     (upd),
		.timeout (timeout_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			timeout_q    <= lct_pkg::TIMEOUT_RST;
			interval_q   <= lct_pkg::INTERVAL_RST;
			last_sweep_q <= 32'd0;
			inj_s0       <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					lct_pkg::REG_TIMEOUT: timeout_q  <= cfg_wdata;
					lct_pkg::REG_SWEEP:   interval_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						inj_s0  <= new_word;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// drop the word once the first cell has taken it
					inj_s0.valid <= 1'b0;
					if (chain_out.valid) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (push) begin
						if (reinject) begin
							// resume the sweep behind the freed slot
							inj_s0  <= resume_word;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_IDLE;
						end
						if (sweep_done) begin
							last_sweep_q <= fin_q.now;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && chain_out.valid) begin
			fin_q <= chain_out;
		end
		if (push) begin
			out_slot_q   <= r_slot;
			out_found_q  <= r_found;
			out_en_q     <= r_en;
			out_closed_q <= r_closed;
			out_cnow_q   <= r_cnow;
			out_last_q   <= r_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_cnow_q, out_closed_q, out_en_q, out_found_q, out_slot_q};
	assign m_tlast  = out_last_q;

	a_idle_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !inj_s0.valid)
		else $error("word injected while idle");

	a_word_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.valid |-> (state_q == ST_RUN))
		else $error("word left the row outside the run state");

	a_upd_with_push: assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |-> push)
		else $error("slot written without a result");

	a_push_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> m_valid_q)
		else $error("result lost");

	a_reinject_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(push && reinject) |=> (inj_s0.valid && (inj_s0.op == lct_pkg::OP_TICK)))
		else $error("sweep not resumed");

endmodule
